### hw/rtl/npq_pkg.sv
// shared types, register indexes and helper functions for the prediction decoder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package npq_pkg;

	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTS_LOW  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTS_HIGH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NORM_IN      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_NORM_OUT     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ERROR_STEP   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVATION   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_PLANE_ROWS   = 3'd7;

	localparam logic [1:0] ACT_TANH    = 2'd0;
	localparam logic [1:0] ACT_SIGMOID = 2'd1;

	localparam logic [15:0] CODE_UNPRED = 16'd0;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SETUP,
		ST_READ,
		ST_NORM,
		ST_MAC,
		ST_LACC,
		ST_SUM,
		ST_TANH,
		ST_TANH2,
		ST_OUT,
		ST_OUT2,
		ST_ADJ,
		ST_DONE
	} state_t;

	// saturate a wide signed value to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [67:0] x);
		logic signed [31:0] r;
		if (x > 68'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (x < -68'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

	// tanh samples at steps of 0.25 over [0,4], q16.16
	function automatic logic [16:0] tanh_tab(input logic [4:0] idx);
		logic [16:0] r;
		case (idx)
			5'd0:    r = 17'd0;
			5'd1:    r = 17'd16051;
			5'd2:    r = 17'd30285;
			5'd3:    r = 17'd41625;
			5'd4:    r = 17'd49912;
			5'd5:    r = 17'd55593;
			5'd6:    r = 17'd59320;
			5'd7:    r = 17'd61694;
			5'd8:    r = 17'd63178;
			5'd9:    r = 17'd64096;
			5'd10:   r = 17'd64659;
			5'd11:   r = 17'd65000;
			5'd12:   r = 17'd65212;
			5'd13:   r = 17'd65339;
			5'd14:   r = 17'd65417;
			5'd15:   r = 17'd65464;
			5'd16:   r = 17'd65492;
			default: r = 17'd65492;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/npq_hist_ram.sv
// history memory of decoded values, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module npq_hist_ram #(
	parameter int DEPTH = 65793,
	parameter int AW    = 17
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [31:0]   wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [31:0]   rdata
);

	logic [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### hw/rtl/nn_prediction_quant_decoder_3d.sv
// top level of the 3-d error-bounded prediction decoder
// depends on npq_pkg and npq_hist_ram
`timescale 1ns / 1ps
`default_nettype none

// Decodes one quantization code per grid point (z fastest, then y, then x) into a
// saturated q16.16 value. Points with all three coordinates nonzero are predicted by a
// 7-tap weighted sum of input-normalized neighbours plus bias, an optional tanh or
// sigmoid and an output affine map; the other points use the lorenzo predictor with
// missing neighbours as zero. A nonzero code adds (code-32768)*error_step, a zero code
// passes raw_value through. One item is worked at a time, and its steps run in turn on
// the one shared 33x33 multiplier, which serves every product in turn, and on the single
// read port of the history memory, read once per neighbour. The history memory holds
// MAX_ROW_LENGTH*MAX_PLANE_ROWS+MAX_ROW_LENGTH+1 values and needs no clearing after
// reset. A finished result sits in an output register, so the next item is taken while
// that result still waits. Configuration is to be written only while the block is idle;
// the user keeps to this, the block itself does not enforce it.

module nn_prediction_quant_decoder_3d #(
	parameter int MAX_ROW_LENGTH = 256,
	parameter int MAX_PLANE_ROWS = 256
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// configuration writes
	input  wire logic                 cfg_we,
	input  wire logic [2:0]           cfg_index,
	input  wire logic [63:0]          cfg_data,
	// input channel
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic                 volume_start,
	input  wire logic [15:0]          quant_code,
	input  wire logic signed [31:0]   raw_value,
	// output channel
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic signed [31:0]        value
);

	localparam int HIST_DEPTH = MAX_ROW_LENGTH * MAX_PLANE_ROWS + MAX_ROW_LENGTH + 1;
	localparam int AW = $clog2(HIST_DEPTH);
	localparam int LW = $clog2(MAX_ROW_LENGTH + 1);
	localparam int PW = $clog2(MAX_PLANE_ROWS + 1);
	localparam int ZW = $clog2(MAX_ROW_LENGTH);
	localparam int YW = $clog2(MAX_PLANE_ROWS);

	// configuration registers
	logic [63:0] weights_low_q, weights_high_q, norm_in_q, norm_out_q;
	logic [30:0] error_step_q;
	logic [1:0]  activation_q;
	logic [8:0]  row_length_q, plane_rows_q;

	// item state
	npq_pkg::state_t    state_q, state_nx;
	logic [2:0]         tap_q;
	logic [LW-1:0]      l_q;
	logic [PW-1:0]      p_q;
	logic [AW-1:0]      pl_q;
	logic [AW-1:0]      wr_ptr_q;
	logic [ZW-1:0]      z_q;
	logic [YW-1:0]      y_q;
	logic               past_plane_q;
	logic [15:0]        code_q;
	logic signed [31:0] raw_q;
	logic signed [51:0] acc_q;
	logic signed [31:0] s_q;
	logic signed [31:0] pred_q;
	logic signed [65:0] prod_q;
	logic               out_valid_q;
	logic signed [31:0] value_q;

	// shared multiplier
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] mul_p;

	logic               hx, hy, hz, interior;
	logic               dx, dy, dz, tap_en, tap_plus;
	logic [AW:0]        tap_off, raddr_w;
	logic [AW-1:0]      raddr;
	logic [31:0]        rdata;
	logic signed [15:0] tap_w;
	logic [63:0]        w_word;
	logic signed [31:0] n_val;
	logic signed [51:0] acc_lz;
	logic signed [31:0] act_x;
	logic signed [32:0] act_ax;
	logic               act_big;
	logic [3:0]         act_i;
	logic [16:0]        act_y;
	logic signed [32:0] act_t;
	logic signed [31:0] act_res;
	logic signed [31:0] result;
	logic               in_fire, done_fire;
	logic [15:0]        l_sel, p_sel;

	assign in_stall  = (state_q != npq_pkg::ST_IDLE);
	assign in_fire   = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign value     = value_q;

	// clamped geometry, taken at each transfer
	always_comb begin
		if (row_length_q == 9'd0) begin
			l_sel = 16'd1;
		end else if ({7'd0, row_length_q} > 16'(MAX_ROW_LENGTH)) begin
			l_sel = 16'(MAX_ROW_LENGTH);
		end else begin
			l_sel = {7'd0, row_length_q};
		end
		if (plane_rows_q == 9'd0) begin
			p_sel = 16'd1;
		end else if ({7'd0, plane_rows_q} > 16'(MAX_PLANE_ROWS)) begin
			p_sel = 16'(MAX_PLANE_ROWS);
		end else begin
			p_sel = {7'd0, plane_rows_q};
		end
	end

	// neighbour presence and tap geometry
	assign hx       = past_plane_q;
	assign hy       = (y_q != '0);
	assign hz       = (z_q != '0);
	assign interior = hx && hy && hz;
	assign dx       = !tap_q[2];
	assign dy       = !tap_q[1];
	assign dz       = !tap_q[0];
	assign tap_en   = (!dx || hx) && (!dy || hy) && (!dz || hz);
	assign tap_plus = dx ^ dy ^ dz;
	assign tap_off  = (dx ? {1'b0, pl_q} : '0) + (dy ? (AW+1)'(l_q) : '0)
		+ (dz ? (AW+1)'(1) : '0);

	// ring address of the neighbour, wr_ptr - offset modulo depth
	always_comb begin
		raddr_w = {1'b0, wr_ptr_q} + (AW+1)'(HIST_DEPTH) - tap_off;
		if (raddr_w >= (AW+1)'(HIST_DEPTH)) begin
			raddr_w = raddr_w - (AW+1)'(HIST_DEPTH);
		end
		raddr = raddr_w[AW-1:0];
	end

	assign w_word = tap_q[2] ? weights_high_q : weights_low_q;
	assign tap_w  = w_word[{tap_q[1:0], 4'b0000} +: 16];
	assign n_val  = npq_pkg::sat32(68'(prod_q >>> 16) + 68'($signed(norm_in_q[31:0])));

	// lorenzo term added or taken away
	always_comb begin
		acc_lz = acc_q;
		if (tap_en) begin
			if (tap_plus) begin
				acc_lz = acc_q + 52'($signed(rdata));
			end else begin
				acc_lz = acc_q - 52'($signed(rdata));
			end
		end
	end

	// activation by table and linear interpolation
	always_comb begin
		act_x   = (activation_q == npq_pkg::ACT_SIGMOID) ? (s_q >>> 1) : s_q;
		act_ax  = act_x[31] ? -33'(act_x) : 33'(act_x);
		act_big = (act_ax >= 33'sd262144);
		act_i   = act_ax[17:14];
		if (act_big) begin
			act_y = npq_pkg::tanh_tab(5'd16);
		end else begin
			act_y = npq_pkg::tanh_tab({1'b0, act_i}) + 17'(prod_q >>> 14);
		end
		act_t = act_x[31] ? -33'($signed({1'b0, act_y})) : 33'($signed({1'b0, act_y}));
		if (activation_q == npq_pkg::ACT_SIGMOID) begin
			act_res = 32'((33'sd65536 + act_t) >>> 1);
		end else begin
			act_res = 32'(act_t);
		end
	end

	// final value with code adjustment
	always_comb begin
		if (code_q == npq_pkg::CODE_UNPRED) begin
			result = raw_q;
		end else begin
			result = npq_pkg::sat32(68'(pred_q) + 68'(prod_q));
		end
	end

	assign mul_p = mul_a * mul_b;

	// sequencer: next state and multiplier operands
	always_comb begin
		state_nx  = state_q;
		mul_a     = '0;
		mul_b     = '0;
		done_fire = 1'b0;
		case (state_q)
			npq_pkg::ST_IDLE: begin
				if (in_fire) begin
					state_nx = npq_pkg::ST_SETUP;
				end
			end
			npq_pkg::ST_SETUP: begin
				mul_a    = 33'(l_q);
				mul_b    = 33'(p_q);
				state_nx = npq_pkg::ST_READ;
			end
			npq_pkg::ST_READ: begin
				state_nx = interior ? npq_pkg::ST_NORM : npq_pkg::ST_LACC;
			end
			npq_pkg::ST_NORM: begin
				mul_a    = 33'($signed(norm_in_q[63:32]));
				mul_b    = 33'($signed(rdata));
				state_nx = npq_pkg::ST_MAC;
			end
			npq_pkg::ST_MAC: begin
				mul_a    = 33'(tap_w);
				mul_b    = 33'(n_val);
				state_nx = (tap_q == 3'd6) ? npq_pkg::ST_SUM : npq_pkg::ST_READ;
			end
			npq_pkg::ST_LACC: begin
				state_nx = (tap_q == 3'd6) ? npq_pkg::ST_ADJ : npq_pkg::ST_READ;
			end
			npq_pkg::ST_SUM: begin
				if (activation_q == npq_pkg::ACT_TANH || activation_q == npq_pkg::ACT_SIGMOID) begin
					state_nx = npq_pkg::ST_TANH;
				end else begin
					state_nx = npq_pkg::ST_OUT;
				end
			end
			npq_pkg::ST_TANH: begin
				// slope between neighbouring samples times the fraction
				mul_a    = 33'(npq_pkg::tanh_tab(5'(act_i) + 5'd1) - npq_pkg::tanh_tab({1'b0, act_i}));
				mul_b    = 33'(act_ax[13:0]);
				state_nx = npq_pkg::ST_TANH2;
			end
			npq_pkg::ST_TANH2: begin
				state_nx = npq_pkg::ST_OUT;
			end
			npq_pkg::ST_OUT: begin
				mul_a    = 33'($signed(norm_out_q[63:32]));
				mul_b    = 33'(s_q);
				state_nx = npq_pkg::ST_OUT2;
			end
			npq_pkg::ST_OUT2: begin
				state_nx = npq_pkg::ST_ADJ;
			end
			npq_pkg::ST_ADJ: begin
				mul_a    = 33'($signed({1'b0, code_q})) - 33'sd32768;
				mul_b    = 33'(error_step_q);
				state_nx = npq_pkg::ST_DONE;
			end
			npq_pkg::ST_DONE: begin
				// wait while the output register still holds an untaken result
				if (!out_valid_q || !out_stall) begin
					done_fire = 1'b1;
					state_nx  = npq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nx = npq_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= npq_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weights_low_q  <= '0;
			weights_high_q <= '0;
			norm_in_q      <= 64'h0001_0000_0000_0000;
			norm_out_q     <= 64'h0001_0000_0000_0000;
			error_step_q   <= '0;
			activation_q   <= 2'd2;
			row_length_q   <= 9'd256;
			plane_rows_q   <= 9'd256;
		end else if (cfg_we) begin
			case (cfg_index)
				npq_pkg::CFG_WEIGHTS_LOW:  weights_low_q  <= cfg_data;
				npq_pkg::CFG_WEIGHTS_HIGH: weights_high_q <= cfg_data;
				npq_pkg::CFG_NORM_IN:      norm_in_q      <= cfg_data;
				npq_pkg::CFG_NORM_OUT:     norm_out_q     <= cfg_data;
				npq_pkg::CFG_ERROR_STEP:   error_step_q   <= cfg_data[30:0];
				npq_pkg::CFG_ACTIVATION:   activation_q   <= cfg_data[1:0];
				npq_pkg::CFG_ROW_LENGTH:   row_length_q   <= cfg_data[8:0];
				npq_pkg::CFG_PLANE_ROWS:   plane_rows_q   <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	// raster position and ring pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q     <= '0;
			z_q          <= '0;
			y_q          <= '0;
			past_plane_q <= 1'b0;
			tap_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (in_fire && volume_start) begin
				z_q          <= '0;
				y_q          <= '0;
				past_plane_q <= 1'b0;
			end
			if (state_q == npq_pkg::ST_SETUP) begin
				tap_q <= '0;
			end else if (state_q == npq_pkg::ST_MAC || state_q == npq_pkg::ST_LACC) begin
				tap_q <= tap_q + 3'd1;
			end
			if (done_fire) begin
				wr_ptr_q <= (wr_ptr_q == AW'(HIST_DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
				if ((LW+1)'(z_q) + (LW+1)'(1) >= (LW+1)'(l_q)) begin
					z_q <= '0;
					if ((PW+1)'(y_q) + (PW+1)'(1) >= (PW+1)'(p_q)) begin
						y_q          <= '0;
						past_plane_q <= 1'b1;
					end else begin
						y_q <= y_q + YW'(1);
					end
				end else begin
					z_q <= z_q + ZW'(1);
				end
			end
			if (done_fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			code_q <= quant_code;
			raw_q  <= raw_value;
			l_q    <= l_sel[LW-1:0];
			p_q    <= p_sel[PW-1:0];
		end
		case (state_q)
			npq_pkg::ST_SETUP: begin
				pl_q  <= mul_p[AW-1:0];
				// bias enters the sum at 28 fraction bits
				acc_q <= interior ? (52'($signed(weights_high_q[63:48])) <<< 16) : '0;
			end
			npq_pkg::ST_NORM: begin
				prod_q <= mul_p;
			end
			npq_pkg::ST_MAC: begin
				acc_q <= acc_q + 52'(mul_p);
			end
			npq_pkg::ST_LACC: begin
				acc_q <= acc_lz;
				if (tap_q == 3'd6) begin
					pred_q <= npq_pkg::sat32(68'(acc_lz));
				end
			end
			npq_pkg::ST_SUM: begin
				s_q <= npq_pkg::sat32(68'(acc_q >>> 12));
			end
			npq_pkg::ST_TANH: begin
				prod_q <= mul_p;
			end
			npq_pkg::ST_TANH2: begin
				s_q <= act_res;
			end
			npq_pkg::ST_OUT: begin
				prod_q <= mul_p;
			end
			npq_pkg::ST_OUT2: begin
				pred_q <= npq_pkg::sat32(68'(prod_q >>> 16) + 68'($signed(norm_out_q[31:0])));
			end
			npq_pkg::ST_ADJ: begin
				prod_q <= mul_p;
			end
			default: ;
		endcase
		if (done_fire) begin
			value_q <= result;
		end
	end

	npq_hist_ram #(
		.DEPTH (HIST_DEPTH),
		.AW    (AW)
	) u_hist (
		.clk   (clk),
		.we    (done_fire),
		.waddr (wr_ptr_q),
		.wdata (result),
		.raddr (raddr),
		.rdata (rdata)
	);

endmodule

`default_nettype wire

### tb/tb_nn_prediction_quant_decoder_3d.sv
// testbench for the 3-d error-bounded prediction decoder
// depends on npq_pkg and the decoder rtl; holds its own predictor and scoreboard
`timescale 1ns / 1ps

module tb_nn_prediction_quant_decoder_3d;

	localparam int MAXL = 256;
	localparam int MAXP = 256;
	localparam int HDEPTH = MAXL * MAXP + MAXL + 1;

	// decoder predictor and store of expected values
	class decode_board;
		logic [63:0] w_lo, w_hi, nin, nout;
		logic [30:0] step;
		logic [1:0] act;
		logic [8:0] rlen, prows;
		logic signed [31:0] hist[];
		int wp, zp, yp;
		bit past_plane;
		logic signed [31:0] expected_values[$];
		int mismatches;

		function new();
			hist = new[HDEPTH];
			w_lo = 0; w_hi = 0;
			nin = 64'h1 << 48; nout = 64'h1 << 48;
			step = 0; act = 2; rlen = 256; prows = 256;
			wp = 0; zp = 0; yp = 0; past_plane = 0;
			mismatches = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [63:0] d);
			case (idx)
				npq_pkg::CFG_WEIGHTS_LOW:  w_lo = d;
				npq_pkg::CFG_WEIGHTS_HIGH: w_hi = d;
				npq_pkg::CFG_NORM_IN:      nin = d;
				npq_pkg::CFG_NORM_OUT:     nout = d;
				npq_pkg::CFG_ERROR_STEP:   step = d[30:0];
				npq_pkg::CFG_ACTIVATION:   act = d[1:0];
				npq_pkg::CFG_ROW_LENGTH:   rlen = d[8:0];
				npq_pkg::CFG_PLANE_ROWS:   prows = d[8:0];
				default: ;
			endcase
		endfunction

		function logic signed [31:0] clip(longint x);
			if (x > 64'sd2147483647) return 32'sh7fffffff;
			if (x < -64'sd2147483648) return 32'sh80000000;
			return x[31:0];
		endfunction

		function logic signed [31:0] remap(logic [63:0] m, logic signed [31:0] v);
			longint g, o;
			g = $signed(m[63:32]);
			o = $signed(m[31:0]);
			return clip(((g * longint'(v)) >>> 16) + o);
		endfunction

		function logic signed [31:0] tanh_q(logic signed [31:0] x);
			longint a, y, f, t0, t1;
			int i;
			a = x < 0 ? -longint'(x) : longint'(x);
			if (a >= (64'sd4 << 16)) y = npq_pkg::tanh_tab(5'd16);
			else begin
				i = int'(a >> 14);
				f = a & 16383;
				t0 = npq_pkg::tanh_tab(i[4:0]);
				t1 = npq_pkg::tanh_tab(i[4:0] + 5'd1);
				y = t0 + (((t1 - t0) * f) >>> 14);
			end
			return 32'(x < 0 ? -y : y);
		endfunction

		function logic signed [31:0] back(int d);
			return hist[wp >= d ? wp - d : wp + HDEPTH - d];
		endfunction

		function void note_input(bit vs, logic [15:0] code, logic signed [31:0] raw);
			int len, rows, pl, t;
			bit hx, hy, hz;
			longint acc, pred, w;
			logic signed [31:0] s, res;
			int offs[7];
			len = rlen == 0 ? 1 : (rlen > MAXL ? MAXL : rlen);
			rows = prows == 0 ? 1 : (prows > MAXP ? MAXP : prows);
			pl = len * rows;
			if (vs) begin
				zp = 0; yp = 0; past_plane = 0;
			end
			hx = past_plane; hy = yp != 0; hz = zp != 0;
			if (hx && hy && hz) begin
				offs = '{pl + len + 1, pl + len, pl + 1, pl, len + 1, len, 1};
				acc = longint'($signed(w_hi[63:48])) * 65536;
				for (t = 0; t < 7; t++) begin
					w = t < 4 ? $signed(w_lo[16*t +: 16]) : $signed(w_hi[16*(t-4) +: 16]);
					acc += w * longint'(remap(nin, back(offs[t])));
				end
				s = clip(acc >>> 12);
				if (act == npq_pkg::ACT_TANH) s = tanh_q(s);
				else if (act == npq_pkg::ACT_SIGMOID)
					s = 32'((longint'(65536) + longint'(tanh_q(s >>> 1))) >>> 1);
				pred = remap(nout, s);
			end else begin
				pred = 0;
				if (hx) pred += back(pl);
				if (hy) pred += back(len);
				if (hz) pred += back(1);
				if (hx && hy) pred -= back(pl + len);
				if (hx && hz) pred -= back(pl + 1);
				if (hy && hz) pred -= back(len + 1);
				if (hx && hy && hz) pred += back(pl + len + 1);
			end
			if (code == npq_pkg::CODE_UNPRED) res = raw;
			else res = clip(longint'(clip(pred)) +
				(longint'(code) - 32768) * longint'(step));
			hist[wp] = res;
			wp = wp + 1 >= HDEPTH ? 0 : wp + 1;
			if (zp + 1 >= len) begin
				zp = 0;
				if (yp + 1 >= rows) begin
					yp = 0; past_plane = 1;
				end else yp++;
			end else zp++;
			expected_values.push_back(res);
		endfunction

		function void check_value(logic signed [31:0] got);
			logic signed [31:0] want;
			if (expected_values.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %0d", got);
				return;
			end
			want = expected_values.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("value mismatch: expected %0d, got %0d", want, got);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [2:0] cfg_index = '0;
	logic [63:0] cfg_data = '0;
	logic in_valid = 0;
	logic in_stall;
	logic volume_start = 0;
	logic [15:0] quant_code = '0;
	logic signed [31:0] raw_value = '0;
	logic out_valid;
	logic out_stall = 0;
	logic signed [31:0] value;

	decode_board board = new();
	bit hold_output = 0;   // long receiver hold-off request
	bit stim_done = 0;

	always #1 clk = ~clk;

	nn_prediction_quant_decoder_3d uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.volume_start(volume_start), .quant_code(quant_code), .raw_value(raw_value),
		.out_valid(out_valid), .out_stall(out_stall), .value(value)
	);

	// register write, mirrored in the predictor
	task automatic write_reg(logic [2:0] idx, logic [63:0] d);
		@(posedge clk);
		cfg_we <= 1; cfg_index <= idx; cfg_data <= d;
		board.write_reg(idx, d);
		@(posedge clk);
		cfg_we <= 0;
	endtask

	// one input transfer with a random gap in front; valid stays up when there is no gap
	task automatic send_point(bit vs, logic [15:0] code, logic signed [31:0] raw, bit gaps);
		int gap;
		gap = gaps ? $urandom_range(0, 14) : 0;
		if (gaps && $urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1; volume_start <= vs; quant_code <= code; raw_value <= raw;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		board.note_input(vs, code, raw);
	endtask

	// wait until every expected value has come, then let the block settle
	task automatic drain();
		in_valid <= 0;
		while (board.expected_values.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// mostly small codes near center so predictions stay meaningful
	function automatic logic [15:0] rand_code();
		case ($urandom_range(0, 9))
			0: return npq_pkg::CODE_UNPRED;
			1: return 16'($urandom_range(0, 65535));
			default: return 16'(32768 + $urandom_range(0, 64) - 32);
		endcase
	endfunction

	function automatic logic signed [31:0] rand_raw();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return 32'sh7fffffff;
			2: return 32'sh80000000;
			default: return $signed($urandom_range(0, 2 * 65536 * 64)) - 65536 * 64;
		endcase
	endfunction

	// one volume start followed by random content for the given number of points
	task automatic send_volume(int pts, bit gaps);
		int i;
		for (i = 0; i < pts; i++)
			send_point(i == 0, rand_code(), rand_raw(), gaps);
	endtask

	// receiver: each taken value is checked; the stall below is random per transfer, plus a long hold-off on request
	always @(posedge clk) begin
		if (out_valid && !out_stall) board.check_value(value);
	end

	initial begin
		int wait_n;
		bit hold_done;
		hold_done = 0;
		forever begin
			@(posedge clk);
			if (hold_output && !hold_done) begin
				hold_done = 1;
				out_stall <= 1;
				repeat (300) @(posedge clk);
			end
			wait_n = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
			if (stim_done && $urandom_range(0, 1) == 0) wait_n = 0;
			if (wait_n > 0) begin
				out_stall <= 1;
				repeat (wait_n) @(posedge clk);
			end
			out_stall <= 0;
			@(posedge clk);
			while (!out_valid && !(hold_output && !hold_done)) @(posedge clk);
		end
	end

	initial begin
		int k, r, l, p, act_sel;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: reset weights and activation, small geometry, extremes of code and raw, lorenzo boundary points
		write_reg(npq_pkg::CFG_ROW_LENGTH, 64'd4);
		write_reg(npq_pkg::CFG_PLANE_ROWS, 64'd3);
		write_reg(npq_pkg::CFG_ERROR_STEP, 64'h7fffffff);
		send_point(1, npq_pkg::CODE_UNPRED, 32'sh7fffffff, 0);
		send_point(0, 16'hffff, 32'sh0, 0);
		send_point(0, 16'h0001, 32'sh0, 0);
		send_point(0, 16'h8000, 32'sh80000000, 0);
		send_point(0, npq_pkg::CODE_UNPRED, 32'sh80000000, 0);
		drain();
		write_reg(npq_pkg::CFG_ERROR_STEP, 64'd0);
		write_reg(npq_pkg::CFG_ERROR_STEP, 64'd65536);
		// a 2x2x2 volume with full-scale weights, each activation setting; its last point is interior
		for (act_sel = 0; act_sel < 4; act_sel++) begin
			write_reg(npq_pkg::CFG_ACTIVATION, 64'(act_sel));
			write_reg(npq_pkg::CFG_WEIGHTS_LOW, 64'h7fff_8000_1000_f000);
			write_reg(npq_pkg::CFG_WEIGHTS_HIGH, 64'h8000_7fff_0800_1000);
			write_reg(npq_pkg::CFG_NORM_IN,
				act_sel[0] ? 64'h7fffffff_80000000 : 64'h00010000_00000000);
			write_reg(npq_pkg::CFG_NORM_OUT,
				act_sel[1] ? 64'h80000000_7fffffff : 64'h00020000_00001000);
			write_reg(npq_pkg::CFG_ROW_LENGTH, 64'd2);
			write_reg(npq_pkg::CFG_PLANE_ROWS, 64'd2);
			send_volume(8, 0);
			drain();
		end
		// geometry at its extremes, including zero and above maximum
		write_reg(npq_pkg::CFG_ROW_LENGTH, 64'd0);
		write_reg(npq_pkg::CFG_PLANE_ROWS, 64'd511);
		send_volume(6, 0);
		drain();

		// random phases
		for (r = 0; r < 40; r++) begin
			l = $urandom_range(0, 5) == 0 ? $urandom_range(0, 511) : $urandom_range(1, 6);
			p = $urandom_range(0, 5) == 0 ? $urandom_range(0, 511) : $urandom_range(1, 5);
			write_reg(npq_pkg::CFG_ROW_LENGTH, 64'(l));
			write_reg(npq_pkg::CFG_PLANE_ROWS, 64'(p));
			write_reg(npq_pkg::CFG_WEIGHTS_LOW, {$urandom, $urandom});
			write_reg(npq_pkg::CFG_WEIGHTS_HIGH, {$urandom, $urandom});
			write_reg(npq_pkg::CFG_NORM_IN, $urandom_range(0, 1) ? 64'h00010000_00000000 :
				{$urandom, $urandom});
			write_reg(npq_pkg::CFG_NORM_OUT, $urandom_range(0, 1) ? {32'h00008000, $urandom} :
				{$urandom, $urandom});
			write_reg(npq_pkg::CFG_ERROR_STEP, $urandom_range(0, 3) == 0 ?
				64'({1'b0, $urandom}) : 64'($urandom_range(0, 4096)));
			write_reg(npq_pkg::CFG_ACTIVATION, 64'($urandom_range(0, 3)));
			if (r == 5) begin
				hold_output <= 1;
			end
			for (k = 0; k < 45; k++) begin
				// a volume start may come mid-volume; it always opens at (0,0,0)
				if (k == 0 || $urandom_range(0, 15) == 0) send_point(1, rand_code(), rand_raw(), 1);
				else send_point(0, rand_code(), rand_raw(), 1);
			end
			// sender pauses until every value has come
			drain();
		end
		stim_done = 1;
		drain();
		if (board.mismatches == 0 && board.expected_values.size() == 0)
			$display("tb_nn_prediction_quant_decoder_3d: done, clean");
		else
			$display("tb_nn_prediction_quant_decoder_3d: done, errors");
		$finish;
	end

	initial begin
		#4000000;
		$display("tb_nn_prediction_quant_decoder_3d: done, errors");
		$finish;
	end

endmodule

### files.f
hw/rtl/npq_pkg.sv
hw/rtl/npq_hist_ram.sv
hw/rtl/nn_prediction_quant_decoder_3d.sv
tb/tb_nn_prediction_quant_decoder_3d.sv
